@@ rtl/core/dmbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth map bilinear sampler package
// Frame geometry, datapath widths, codes and shared types.
// ----------------------------------------------------------------------------
package dmbs_pkg;

    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;
    localparam int FRAME_SIZE   = FRAME_WIDTH * FRAME_HEIGHT;

    localparam int COL_W  = $clog2(FRAME_WIDTH);
    localparam int ROW_W  = $clog2(FRAME_HEIGHT);
    localparam int HCOL_W = (COL_W > 1) ? COL_W - 1 : 1;
    localparam int HROW_W = (ROW_W > 1) ? ROW_W - 1 : 1;
    localparam int HALF_W = (FRAME_WIDTH + 1) / 2;
    localparam int HALF_H = (FRAME_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int NUM_BANKS = 4;

    localparam int ADDR_W     = 19;
    localparam int VAL_W      = 8;
    localparam int QRY_W      = 24;
    localparam int RES_W      = 17;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam int MAG_W = QRY_W + 10;
    localparam int NUM_W = MAG_W + 8;
    localparam int DEN_W = 16;

    localparam int DX_W   = NUM_W + 3;
    localparam int LO_W   = 23;
    localparam int HI_W   = DX_W - LO_W;
    localparam int PL_W   = 16 + LO_W + 1;
    localparam int PH_W   = 16 + HI_W;
    localparam int PROD_W = 16 + DX_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RX_W   = SUM_W - 13;

    localparam int RW_SH = ADDR_W;
    localparam logic [RW_SH-1:0] ADDR_RECIP = RW_SH'((64'd1 << RW_SH) / FRAME_WIDTH);

    localparam logic [39:0] ROUND_ADD  = 40'(255 * 32768);
    localparam logic [16:0] RECIP_255  = 17'd65793;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WORLD_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORLD_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_LEFT    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_RIGHT   = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_TOP     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_BOTTOM  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_COS      = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_SIN      = 8'd7;

    typedef struct packed {
        logic             valid;
        logic             op;
        logic             wr_ok;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_side;

    typedef struct packed {
        logic                               wr_en;
        logic [1:0]                         wr_bank;
        logic [BANK_AW-1:0]                 wr_addr;
        logic [VAL_W-1:0]                   wr_data;
        logic [NUM_BANKS-1:0][BANK_AW-1:0]  rd_addr;
    } t_mem_req;

endpackage

@@ rtl/core/depth_map_bilinear_sampler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth map bilinear sampler
// Banked depth frame with pixel writes and rotated-crop bilinear queries.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// request   in         start & !busy            operation, pixel_address,
//                                               pixel_value, query_x, query_y
// result    out        o_strobe, one cycle      height_fraction
// config    in         i_cfg_valid & o_cfg_ready i_cfg_index, i_cfg_data
//
// One request per cycle while busy is low. A query result passes through the
// 43-stage scale divider, then the rotate, memory and blend stages, to o_strobe.
// A write lands in the frame at the same stage where queries read it, so
// order is kept. busy is high only until r_run is set after reset; no clearing pass.
// ----------------------------------------------------------------------------
module depth_map_bilinear_sampler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_operation,
    input  logic [dmbs_pkg::ADDR_W-1:0]       i_pixel_address,
    input  logic [dmbs_pkg::VAL_W-1:0]        i_pixel_value,
    input  logic [dmbs_pkg::QRY_W-1:0]        i_query_x,
    input  logic [dmbs_pkg::QRY_W-1:0]        i_query_y,
    output logic                              o_strobe,
    output logic [dmbs_pkg::RES_W-1:0]        o_height_fraction,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dmbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dmbs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam logic signed [dmbs_pkg::RX_W-1:0] X_MAX =
        dmbs_pkg::RX_W'(64'(dmbs_pkg::FRAME_WIDTH - 1) << 16);
    localparam logic signed [dmbs_pkg::RX_W-1:0] Y_MAX =
        dmbs_pkg::RX_W'(64'(dmbs_pkg::FRAME_HEIGHT - 1) << 16);

    function automatic logic [dmbs_pkg::BANK_AW-1:0] bank_addr(
        input logic [dmbs_pkg::ROW_W-1:0] row,
        input logic [dmbs_pkg::COL_W-1:0] col
    );
        logic [dmbs_pkg::HROW_W-1:0] rh;
        logic [dmbs_pkg::HCOL_W-1:0] ch;
        logic [31:0]                 a;
        rh = dmbs_pkg::HROW_W'(row >> 1);
        ch = dmbs_pkg::HCOL_W'(col >> 1);
        a  = 32'(rh) * 32'(dmbs_pkg::HALF_W) + 32'(ch);
        return dmbs_pkg::BANK_AW'(a);
    endfunction

    // configuration
    logic        r_run;
    logic [15:0] r_world_width, r_world_height;
    logic [9:0]  r_crop_left, r_crop_right;
    logic [8:0]  r_crop_top, r_crop_bottom;
    logic signed [15:0] r_rot_cos, r_rot_sin;

    assign busy        = ~r_run;
    assign o_cfg_ready = r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run          <= 1'b0;
            r_world_width  <= 16'd640;
            r_world_height <= 16'd480;
            r_crop_left    <= 10'd0;
            r_crop_right   <= 10'd640;
            r_crop_top     <= 9'd0;
            r_crop_bottom  <= 9'd480;
            r_rot_cos      <= 16'sd16384;
            r_rot_sin      <= 16'sd0;
        end else begin
            r_run <= 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    dmbs_pkg::CFG_WORLD_WIDTH:  r_world_width  <= i_cfg_data;
                    dmbs_pkg::CFG_WORLD_HEIGHT: r_world_height <= i_cfg_data;
                    dmbs_pkg::CFG_CROP_LEFT:    r_crop_left    <= i_cfg_data[9:0];
                    dmbs_pkg::CFG_CROP_RIGHT:   r_crop_right   <= i_cfg_data[9:0];
                    dmbs_pkg::CFG_CROP_TOP:     r_crop_top     <= i_cfg_data[8:0];
                    dmbs_pkg::CFG_CROP_BOTTOM:  r_crop_bottom  <= i_cfg_data[8:0];
                    dmbs_pkg::CFG_ROT_COS:      r_rot_cos      <= $signed(i_cfg_data);
                    dmbs_pkg::CFG_ROT_SIN:      r_rot_sin      <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // derived config terms; the user must keep them static while requests are in flight, the block does not enforce it
    logic [15:0]        den_x, den_y;
    logic signed [10:0] bw;
    logic signed [9:0]  bh;
    logic [9:0]         mag_x;
    logic [8:0]         mag_y;
    logic               sign_x, sign_y;
    logic [10:0]        sum_x;
    logic [9:0]         sum_y;
    logic [25:0]        cx, cy;
    logic [dmbs_pkg::DX_W-1:0] off_x, off_y;

    always_comb begin
        den_x  = (r_world_width == 16'd0) ? 16'd1 : r_world_width;
        den_y  = (r_world_height == 16'd0) ? 16'd1 : r_world_height;
        bw     = $signed({1'b0, r_crop_right}) - $signed({1'b0, r_crop_left});
        bh     = $signed({1'b0, r_crop_bottom}) - $signed({1'b0, r_crop_top});
        sign_x = bw[10];
        sign_y = bh[9];
        mag_x  = sign_x ? 10'(-bw) : bw[9:0];
        mag_y  = sign_y ? 9'(-bh) : bh[8:0];
        sum_x  = {1'b0, r_crop_left} + {1'b0, r_crop_right};
        sum_y  = {1'b0, r_crop_top} + {1'b0, r_crop_bottom};
        cx     = {sum_x, 15'd0};
        cy     = {1'b0, sum_y, 15'd0};
        off_x  = dmbs_pkg::DX_W'({r_crop_left, 16'd0}) - dmbs_pkg::DX_W'(cx);
        off_y  = dmbs_pkg::DX_W'({r_crop_top, 16'd0}) - dmbs_pkg::DX_W'(cy);
    end

    // s0: input register
    logic                          accept;
    logic                          r_s0_valid, r_s0_op;
    logic [dmbs_pkg::ADDR_W-1:0]   r_s0_addr;
    logic [dmbs_pkg::VAL_W-1:0]    r_s0_value;
    logic [dmbs_pkg::QRY_W-1:0]    r_s0_qx, r_s0_qy;

    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_op    <= i_operation;
        r_s0_addr  <= i_pixel_address;
        r_s0_value <= i_pixel_value;
        r_s0_qx    <= i_query_x;
        r_s0_qy    <= i_query_y;
    end

    // s1: scale numerators, row estimate of write address
    logic [dmbs_pkg::MAG_W-1:0]    n_s1_nx, n_s1_ny;
    logic [2*dmbs_pkg::ADDR_W-1:0] addr_prod;
    logic                          r_s1_valid, r_s1_op;
    logic [dmbs_pkg::ADDR_W-1:0]   r_s1_addr, r_s1_row_est;
    logic [dmbs_pkg::VAL_W-1:0]    r_s1_value;
    logic [dmbs_pkg::MAG_W-1:0]    r_s1_nx, r_s1_ny;

    always_comb begin
        n_s1_nx   = r_s0_qx * mag_x;
        n_s1_ny   = r_s0_qy * mag_y;
        addr_prod = r_s0_addr * dmbs_pkg::ADDR_RECIP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_op      <= r_s0_op;
        r_s1_addr    <= r_s0_addr;
        r_s1_value   <= r_s0_value;
        r_s1_row_est <= addr_prod[2*dmbs_pkg::ADDR_W-1:dmbs_pkg::RW_SH];
        r_s1_nx      <= n_s1_nx;
        r_s1_ny      <= n_s1_ny;
    end

    // write address correction into row and column
    logic [31:0]                 est_base;
    logic [dmbs_pkg::ADDR_W-1:0] wr_rem, wr_row, wr_col;
    logic                        wr_ge;
    dmbs_pkg::t_side             div_in;

    always_comb begin
        est_base = 32'(r_s1_row_est) * 32'(dmbs_pkg::FRAME_WIDTH);
        wr_rem   = r_s1_addr - dmbs_pkg::ADDR_W'(est_base);
        wr_ge    = (wr_rem >= dmbs_pkg::ADDR_W'(dmbs_pkg::FRAME_WIDTH));
        wr_row   = r_s1_row_est + dmbs_pkg::ADDR_W'(wr_ge);
        wr_col   = wr_ge ? wr_rem - dmbs_pkg::ADDR_W'(dmbs_pkg::FRAME_WIDTH) : wr_rem;
        div_in.valid = r_s1_valid;
        div_in.op    = r_s1_op;
        div_in.wr_ok = (r_s1_op == dmbs_pkg::OP_WRITE) &&
                       (32'(r_s1_addr) < 32'(dmbs_pkg::FRAME_SIZE));
        div_in.row   = dmbs_pkg::ROW_W'(wr_row);
        div_in.col   = dmbs_pkg::COL_W'(wr_col);
        div_in.value = r_s1_value;
    end

    dmbs_pkg::t_side            div_side;
    logic [dmbs_pkg::NUM_W-1:0] quo_x, quo_y;
    logic                       nz_x, nz_y;

    dmbs_scale_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_side     (div_in),
        .i_num_x    ({r_s1_nx, 8'd0}),
        .i_num_y    ({r_s1_ny, 8'd0}),
        .i_den_x    (den_x),
        .i_den_y    (den_y),
        .o_side     (div_side),
        .o_quo_x    (quo_x),
        .o_rem_nz_x (nz_x),
        .o_quo_y    (quo_y),
        .o_rem_nz_y (nz_y)
    );

    // s2: offset from crop center, floor for negative scale
    logic [dmbs_pkg::DX_W-1:0] qv_x, qv_y, n_s2_dx, n_s2_dy;
    logic signed [dmbs_pkg::DX_W-1:0] r_s2_dx, r_s2_dy;
    dmbs_pkg::t_side r_s2_side, r_s3_side, r_s4_side, r_s5_side, r_s6_side;

    always_comb begin
        qv_x    = sign_x ? ~dmbs_pkg::DX_W'(quo_x) : dmbs_pkg::DX_W'(quo_x);
        qv_y    = sign_y ? ~dmbs_pkg::DX_W'(quo_y) : dmbs_pkg::DX_W'(quo_y);
        n_s2_dx = qv_x + off_x + dmbs_pkg::DX_W'(sign_x & ~nz_x);
        n_s2_dy = qv_y + off_y + dmbs_pkg::DX_W'(sign_y & ~nz_y);
    end

    // s3: partial products
    logic signed [dmbs_pkg::PL_W-1:0] r_cx_lo, r_sy_lo, r_sx_lo, r_cy_lo;
    logic signed [dmbs_pkg::PH_W-1:0] r_cx_hi, r_sy_hi, r_sx_hi, r_cy_hi;
    logic signed [dmbs_pkg::LO_W:0]   lo_x, lo_y;
    logic signed [dmbs_pkg::HI_W-1:0] hi_x, hi_y;

    always_comb begin
        lo_x = $signed({1'b0, r_s2_dx[dmbs_pkg::LO_W-1:0]});
        lo_y = $signed({1'b0, r_s2_dy[dmbs_pkg::LO_W-1:0]});
        hi_x = r_s2_dx[dmbs_pkg::DX_W-1:dmbs_pkg::LO_W];
        hi_y = r_s2_dy[dmbs_pkg::DX_W-1:dmbs_pkg::LO_W];
    end

    // s4: full products
    logic signed [dmbs_pkg::PROD_W-1:0] n_pcx, n_psy, n_psx, n_pcy;
    logic signed [dmbs_pkg::PROD_W-1:0] r_pcx, r_psy, r_psx, r_pcy;

    always_comb begin
        n_pcx = $signed({r_cx_hi, {dmbs_pkg::LO_W{1'b0}}}) + dmbs_pkg::PROD_W'(r_cx_lo);
        n_psy = $signed({r_sy_hi, {dmbs_pkg::LO_W{1'b0}}}) + dmbs_pkg::PROD_W'(r_sy_lo);
        n_psx = $signed({r_sx_hi, {dmbs_pkg::LO_W{1'b0}}}) + dmbs_pkg::PROD_W'(r_sx_lo);
        n_pcy = $signed({r_cy_hi, {dmbs_pkg::LO_W{1'b0}}}) + dmbs_pkg::PROD_W'(r_cy_lo);
    end

    // s5: rotation sums
    logic signed [dmbs_pkg::SUM_W-1:0] r_rot_a, r_rot_b;

    // s6: recenter, clamp, split
    logic signed [dmbs_pkg::RX_W-1:0] rx, ry;
    logic [dmbs_pkg::COL_W-1:0] n_x1;
    logic [dmbs_pkg::ROW_W-1:0] n_y1;
    logic [15:0]                n_fx, n_fy;
    logic [dmbs_pkg::COL_W-1:0] r_s6_x1;
    logic [dmbs_pkg::ROW_W-1:0] r_s6_y1;
    logic [15:0]                r_s6_fx, r_s6_fy;

    always_comb begin
        rx = dmbs_pkg::RX_W'($signed(r_rot_a[dmbs_pkg::SUM_W-1:14])) + dmbs_pkg::RX_W'(cx);
        ry = dmbs_pkg::RX_W'($signed(r_rot_b[dmbs_pkg::SUM_W-1:14])) + dmbs_pkg::RX_W'(cy);
        priority if (rx < 0) begin
            n_x1 = '0;
            n_fx = '0;
        end else if (rx > X_MAX) begin
            n_x1 = dmbs_pkg::COL_W'(dmbs_pkg::FRAME_WIDTH - 1);
            n_fx = '0;
        end else begin
            n_x1 = rx[16 +: dmbs_pkg::COL_W];
            n_fx = rx[15:0];
        end
        priority if (ry < 0) begin
            n_y1 = '0;
            n_fy = '0;
        end else if (ry > Y_MAX) begin
            n_y1 = dmbs_pkg::ROW_W'(dmbs_pkg::FRAME_HEIGHT - 1);
            n_fy = '0;
        end else begin
            n_y1 = ry[16 +: dmbs_pkg::ROW_W];
            n_fy = ry[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_side.valid <= 1'b0;
            r_s3_side.valid <= 1'b0;
            r_s4_side.valid <= 1'b0;
            r_s5_side.valid <= 1'b0;
            r_s6_side.valid <= 1'b0;
        end else begin
            r_s2_side <= div_side;
            r_s3_side <= r_s2_side;
            r_s4_side <= r_s3_side;
            r_s5_side <= r_s4_side;
            r_s6_side <= r_s5_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_dx <= $signed(n_s2_dx);
        r_s2_dy <= $signed(n_s2_dy);
        r_cx_lo <= r_rot_cos * lo_x;
        r_sy_lo <= r_rot_sin * lo_y;
        r_sx_lo <= r_rot_sin * lo_x;
        r_cy_lo <= r_rot_cos * lo_y;
        r_cx_hi <= r_rot_cos * hi_x;
        r_sy_hi <= r_rot_sin * hi_y;
        r_sx_hi <= r_rot_sin * hi_x;
        r_cy_hi <= r_rot_cos * hi_y;
        r_pcx   <= n_pcx;
        r_psy   <= n_psy;
        r_psx   <= n_psx;
        r_pcy   <= n_pcy;
        r_rot_a <= dmbs_pkg::SUM_W'(r_pcx) - dmbs_pkg::SUM_W'(r_psy);
        r_rot_b <= dmbs_pkg::SUM_W'(r_psx) + dmbs_pkg::SUM_W'(r_pcy);
        r_s6_x1 <= n_x1;
        r_s6_y1 <= n_y1;
        r_s6_fx <= n_fx;
        r_s6_fy <= n_fy;
    end

    // memory access: query reads and pixel writes at the same stage
    logic [dmbs_pkg::COL_W-1:0] x2, bcol;
    logic [dmbs_pkg::ROW_W-1:0] y2, brow;
    dmbs_pkg::t_mem_req         mem_req;
    logic [dmbs_pkg::VAL_W-1:0] rd_data [dmbs_pkg::NUM_BANKS];

    always_comb begin
        x2 = (r_s6_x1 < dmbs_pkg::COL_W'(dmbs_pkg::FRAME_WIDTH - 1)) ?
             r_s6_x1 + 1'b1 : r_s6_x1;
        y2 = (r_s6_y1 < dmbs_pkg::ROW_W'(dmbs_pkg::FRAME_HEIGHT - 1)) ?
             r_s6_y1 + 1'b1 : r_s6_y1;
        bcol = r_s6_x1;
        brow = r_s6_y1;
        for (int b = 0; b < dmbs_pkg::NUM_BANKS; b++) begin
            bcol = (r_s6_x1[0] == b[0]) ? r_s6_x1 : x2;
            brow = (r_s6_y1[0] == b[1]) ? r_s6_y1 : y2;
            mem_req.rd_addr[b] = bank_addr(brow, bcol);
        end
        mem_req.wr_en   = r_s6_side.valid & r_s6_side.wr_ok;
        mem_req.wr_bank = {r_s6_side.row[0], r_s6_side.col[0]};
        mem_req.wr_addr = bank_addr(r_s6_side.row, r_s6_side.col);
        mem_req.wr_data = r_s6_side.value;
    end

    dmbs_frame_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // s7: read data arrives, pick neighbors, first blend
    logic        r_s7_valid, r_s7_x1p, r_s7_x2p, r_s7_y1p, r_s7_y2p;
    logic [15:0] r_s7_fx, r_s7_fy;
    logic [7:0]  z11, z21, z12, z22;
    logic [16:0] wx, fx17;
    logic [23:0] n_r1, n_r2;

    always_comb begin
        z11  = rd_data[{r_s7_y1p, r_s7_x1p}];
        z21  = rd_data[{r_s7_y1p, r_s7_x2p}];
        z12  = rd_data[{r_s7_y2p, r_s7_x1p}];
        z22  = rd_data[{r_s7_y2p, r_s7_x2p}];
        fx17 = {1'b0, r_s7_fx};
        wx   = 17'h10000 - fx17;
        n_r1 = wx * z11 + fx17 * z21;
        n_r2 = wx * z12 + fx17 * z22;
    end

    // s8: second blend
    logic        r_s8_valid;
    logic [23:0] r_s8_r1, r_s8_r2;
    logic [15:0] r_s8_fy;
    logic [16:0] wy, fy17;
    logic [39:0] n_z;

    always_comb begin
        fy17 = {1'b0, r_s8_fy};
        wy   = 17'h10000 - fy17;
        n_z  = wy * r_s8_r1 + fy17 * r_s8_r2;
    end

    // s9/s10: divide by 255 * 65536 with rounding
    logic        r_s9_valid, r_s10_valid;
    logic [39:0] r_s9_z, round_z;
    logic [40:0] recip_prod;
    logic [23:0] r_s10_u, rem255;
    logic [16:0] r_s10_qe, n_res;
    logic [24:0] qe255;

    always_comb begin
        round_z    = r_s9_z + dmbs_pkg::ROUND_ADD;
        recip_prod = round_z[39:16] * dmbs_pkg::RECIP_255;
        qe255      = r_s10_qe * 8'd255;
        rem255     = r_s10_u - qe255[23:0];
        n_res      = r_s10_qe + 17'(rem255 >= 24'd255);
    end

    logic                       r_out_valid;
    logic [dmbs_pkg::RES_W-1:0] r_out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid  <= 1'b0;
            r_s8_valid  <= 1'b0;
            r_s9_valid  <= 1'b0;
            r_s10_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s7_valid  <= r_s6_side.valid & (r_s6_side.op == dmbs_pkg::OP_QUERY);
            r_s8_valid  <= r_s7_valid;
            r_s9_valid  <= r_s8_valid;
            r_s10_valid <= r_s9_valid;
            r_out_valid <= r_s10_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s7_x1p  <= r_s6_x1[0];
        r_s7_x2p  <= x2[0];
        r_s7_y1p  <= r_s6_y1[0];
        r_s7_y2p  <= y2[0];
        r_s7_fx   <= r_s6_fx;
        r_s7_fy   <= r_s6_fy;
        r_s8_r1   <= n_r1;
        r_s8_r2   <= n_r2;
        r_s8_fy   <= r_s7_fy;
        r_s9_z    <= n_z;
        r_s10_u   <= round_z[39:16];
        r_s10_qe  <= recip_prod[40:24];
        r_out_res <= n_res;
    end

    assign o_strobe          = r_out_valid;
    assign o_height_fraction = r_out_res;

endmodule

@@ rtl/core/dmbs_scale_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scale divider
// Pipelined restoring divide, one quotient bit per stage, x and y in parallel.
// ----------------------------------------------------------------------------
module dmbs_scale_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dmbs_pkg::t_side               i_side,
    input  logic [dmbs_pkg::NUM_W-1:0]    i_num_x,
    input  logic [dmbs_pkg::NUM_W-1:0]    i_num_y,
    input  logic [dmbs_pkg::DEN_W-1:0]    i_den_x,
    input  logic [dmbs_pkg::DEN_W-1:0]    i_den_y,
    output dmbs_pkg::t_side               o_side,
    output logic [dmbs_pkg::NUM_W-1:0]    o_quo_x,
    output logic                          o_rem_nz_x,
    output logic [dmbs_pkg::NUM_W-1:0]    o_quo_y,
    output logic                          o_rem_nz_y
);

    logic [dmbs_pkg::DEN_W-1:0] r_rem_x [0:dmbs_pkg::NUM_W];
    logic [dmbs_pkg::NUM_W-1:0] r_num_x [0:dmbs_pkg::NUM_W];
    logic [dmbs_pkg::DEN_W-1:0] r_rem_y [0:dmbs_pkg::NUM_W];
    logic [dmbs_pkg::NUM_W-1:0] r_num_y [0:dmbs_pkg::NUM_W];
    dmbs_pkg::t_side            r_side  [0:dmbs_pkg::NUM_W];

    function automatic logic [dmbs_pkg::DEN_W+dmbs_pkg::NUM_W-1:0] div_step(
        input logic [dmbs_pkg::DEN_W-1:0] rem,
        input logic [dmbs_pkg::NUM_W-1:0] num,
        input logic [dmbs_pkg::DEN_W-1:0] den
    );
        logic [dmbs_pkg::DEN_W:0]   t;
        logic [dmbs_pkg::DEN_W:0]   d;
        logic                       ge;
        logic [dmbs_pkg::DEN_W-1:0] n_rem;
        t  = {rem, num[dmbs_pkg::NUM_W-1]};
        d  = {1'b0, den};
        ge = (t >= d);
        if (ge) begin
            n_rem = dmbs_pkg::DEN_W'(t - d);
        end else begin
            n_rem = t[dmbs_pkg::DEN_W-1:0];
        end
        return {n_rem, num[dmbs_pkg::NUM_W-2:0], ge};
    endfunction

    always_ff @(posedge i_clk) begin
        r_rem_x[0] <= '0;
        r_num_x[0] <= i_num_x;
        r_rem_y[0] <= '0;
        r_num_y[0] <= i_num_y;
        for (int k = 1; k <= dmbs_pkg::NUM_W; k++) begin
            {r_rem_x[k], r_num_x[k]} <= div_step(r_rem_x[k-1], r_num_x[k-1], i_den_x);
            {r_rem_y[k], r_num_y[k]} <= div_step(r_rem_y[k-1], r_num_y[k-1], i_den_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= dmbs_pkg::NUM_W; k++) begin
                r_side[k].valid <= 1'b0;
            end
        end else begin
            r_side[0] <= i_side;
            for (int k = 1; k <= dmbs_pkg::NUM_W; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_side     = r_side[dmbs_pkg::NUM_W];
    assign o_quo_x    = r_num_x[dmbs_pkg::NUM_W];
    assign o_rem_nz_x = |r_rem_x[dmbs_pkg::NUM_W];
    assign o_quo_y    = r_num_y[dmbs_pkg::NUM_W];
    assign o_rem_nz_y = |r_rem_y[dmbs_pkg::NUM_W];

endmodule

@@ rtl/core/dmbs_frame_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame memory
// Four banks by row and column parity, one write and one read each, read
// data registered.
// ----------------------------------------------------------------------------
module dmbs_frame_mem (
    input  logic                         i_clk,
    input  dmbs_pkg::t_mem_req           i_req,
    output logic [dmbs_pkg::VAL_W-1:0]   o_rd_data [dmbs_pkg::NUM_BANKS]
);

    for (genvar b = 0; b < dmbs_pkg::NUM_BANKS; b++) begin : g_bank
        logic [dmbs_pkg::VAL_W-1:0] r_mem [0:dmbs_pkg::BANK_DEPTH-1];
        logic [dmbs_pkg::VAL_W-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (i_req.wr_en && (i_req.wr_bank == 2'(b))) begin
                r_mem[i_req.wr_addr] <= i_req.wr_data;
            end
            r_rd <= r_mem[i_req.rd_addr[b]];
        end

        assign o_rd_data[b] = r_rd;
    end

endmodule

@@ test/tb_depth_map_bilinear_sampler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth map bilinear sampler testbench
// Runs directed and random writes and queries under several crop, world and
// rotation settings; every pixel a query touches is written before it.
// Expected heights come from a bit-exact predictor of the crop, rotate and
// blend arithmetic, and each strobed result is checked in order.
// ----------------------------------------------------------------------------
module tb_depth_map_bilinear_sampler;
    import dmbs_pkg::*;

    localparam int  IDLE_LIMIT = 4000;
    localparam int  SETTLE     = 70;
    localparam longint X_MAX   = longint'(FRAME_WIDTH - 1) * 65536;
    localparam longint Y_MAX   = longint'(FRAME_HEIGHT - 1) * 65536;

    typedef struct {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  value;
        logic [QRY_W-1:0]  qx;
        logic [QRY_W-1:0]  qy;
    } t_request;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_operation = OP_WRITE;
    logic [ADDR_W-1:0]     i_pixel_address = '0;
    logic [VAL_W-1:0]      i_pixel_value = '0;
    logic [QRY_W-1:0]      i_query_x = '0;
    logic [QRY_W-1:0]      i_query_y = '0;
    logic                  o_strobe;
    logic [RES_W-1:0]      o_height_fraction;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_request          request_q[$];
    logic [RES_W-1:0]  height_q[$];
    logic [VAL_W-1:0]  frame_model [FRAME_SIZE];
    bit                pixel_set [FRAME_SIZE];
    int                n_pushed = 0;
    int                errors = 0;
    int                idle_pct = 12;
    int                quiet_cycles = 0;
    logic              taken = 1'b0;

    longint world_w = 640, world_h = 480;
    longint crop_l = 0, crop_r = 640, crop_t = 0, crop_b = 480;
    longint cos_q14 = 16384, sin_q14 = 0;

    depth_map_bilinear_sampler dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint floor_div(longint n, longint d);
        if (n >= 0) return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic longint clip(longint v, longint hi);
        if (v < 0) return 0;
        return (v > hi) ? hi : v;
    endfunction

    function automatic void query_corners(input logic [QRY_W-1:0] qx,
                                          input logic [QRY_W-1:0] qy,
                                          output longint x1, output longint y1,
                                          output longint x2, output longint y2,
                                          output longint fx, output longint fy);
        longint ww, wh, px, py, cx, cy, dx, dy, rx, ry;
        ww = (world_w == 0) ? 1 : world_w;
        wh = (world_h == 0) ? 1 : world_h;
        px = floor_div(longint'(qx) * (crop_r - crop_l) * 256, ww) + crop_l * 65536;
        py = floor_div(longint'(qy) * (crop_b - crop_t) * 256, wh) + crop_t * 65536;
        cx = (crop_l + crop_r) * 32768;
        cy = (crop_t + crop_b) * 32768;
        dx = px - cx;
        dy = py - cy;
        rx = clip(cx + floor_div(cos_q14 * dx - sin_q14 * dy, 16384), X_MAX);
        ry = clip(cy + floor_div(sin_q14 * dx + cos_q14 * dy, 16384), Y_MAX);
        x1 = rx >>> 16;
        y1 = ry >>> 16;
        fx = rx & 65535;
        fy = ry & 65535;
        x2 = (x1 < FRAME_WIDTH - 1) ? x1 + 1 : x1;
        y2 = (y1 < FRAME_HEIGHT - 1) ? y1 + 1 : y1;
    endfunction

    function automatic logic [RES_W-1:0] blended_height(logic [QRY_W-1:0] qx,
                                                         logic [QRY_W-1:0] qy);
        longint x1, y1, x2, y2, fx, fy, r1, r2, z;
        query_corners(qx, qy, x1, y1, x2, y2, fx, fy);
        r1 = (65536 - fx) * frame_model[y1 * FRAME_WIDTH + x1]
           + fx * frame_model[y1 * FRAME_WIDTH + x2];
        r2 = (65536 - fx) * frame_model[y2 * FRAME_WIDTH + x1]
           + fx * frame_model[y2 * FRAME_WIDTH + x2];
        z = (65536 - fy) * r1 + fy * r2;
        return RES_W'((z + 255 * 32768) / (255 * 65536));
    endfunction

    // driver
    always @(negedge i_clk) begin
        t_request r;
        if (!i_rst_n || (start && !taken)) begin
            // hold
        end else if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
            r = request_q.pop_front();
            start           <= 1'b1;
            i_operation     <= r.op;
            i_pixel_address <= r.addr;
            i_pixel_value   <= r.value;
            i_query_x       <= r.qx;
            i_query_y       <= r.qy;
        end else begin
            start <= 1'b0;
        end
    end

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        logic [RES_W-1:0] want;
        taken <= start && !busy && i_rst_n;
        if (i_rst_n && start && !busy) begin
            if (i_operation == OP_QUERY)
                height_q.push_back(blended_height(i_query_x, i_query_y));
            else if (i_pixel_address < FRAME_SIZE)
                frame_model[i_pixel_address] = i_pixel_value;
        end
        if (i_rst_n && o_strobe) begin
            if (height_q.size() == 0) begin
                $error("unexpected result height_fraction=%0d", o_height_fraction);
                errors++;
            end else begin
                want = height_q.pop_front();
                if (o_height_fraction !== want) begin
                    $error("height_fraction expected %0d actual %0d", want,
                           o_height_fraction);
                    errors++;
                end
            end
        end
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_WORLD_WIDTH:  world_w = data;
            CFG_WORLD_HEIGHT: world_h = data;
            CFG_CROP_LEFT:    crop_l = data[9:0];
            CFG_CROP_RIGHT:   crop_r = data[9:0];
            CFG_CROP_TOP:     crop_t = data[8:0];
            CFG_CROP_BOTTOM:  crop_b = data[8:0];
            CFG_ROT_COS:      cos_q14 = longint'($signed(data));
            CFG_ROT_SIN:      sin_q14 = longint'($signed(data));
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setup(int ww, int wh, int cl, int cr, int ct, int cb,
                               int cs, int sn);
        cfg_write(CFG_WORLD_WIDTH, 16'(ww));
        cfg_write(CFG_WORLD_HEIGHT, 16'(wh));
        cfg_write(CFG_CROP_LEFT, 16'(cl));
        cfg_write(CFG_CROP_RIGHT, 16'(cr));
        cfg_write(CFG_CROP_TOP, 16'(ct));
        cfg_write(CFG_CROP_BOTTOM, 16'(cb));
        cfg_write(CFG_ROT_COS, 16'(cs));
        cfg_write(CFG_ROT_SIN, 16'(sn));
    endtask

    task automatic push_write(int addr, int value);
        t_request r;
        r.op = OP_WRITE;
        r.addr = ADDR_W'(addr);
        r.value = VAL_W'(value);
        r.qx = QRY_W'($urandom);
        r.qy = QRY_W'($urandom);
        request_q.push_back(r);
        if (addr >= 0 && addr < FRAME_SIZE)
            pixel_set[addr] = 1'b1;
        n_pushed++;
    endtask

    // write any unwritten neighbor first, then the query
    task automatic push_query(int qx, int qy);
        t_request r;
        longint   x1, y1, x2, y2, fx, fy;
        longint   idx [4];
        query_corners(QRY_W'(qx), QRY_W'(qy), x1, y1, x2, y2, fx, fy);
        idx[0] = y1 * FRAME_WIDTH + x1;
        idx[1] = y1 * FRAME_WIDTH + x2;
        idx[2] = y2 * FRAME_WIDTH + x1;
        idx[3] = y2 * FRAME_WIDTH + x2;
        foreach (idx[k]) begin
            if (!pixel_set[idx[k]])
                push_write(int'(idx[k]), $urandom_range(255));
        end
        r.op = OP_QUERY;
        r.addr = ADDR_W'($urandom);
        r.value = VAL_W'($urandom);
        r.qx = QRY_W'(qx);
        r.qy = QRY_W'(qy);
        request_q.push_back(r);
        n_pushed++;
    endtask

    task automatic push_random(int count);
        int ww, wh, stop;
        ww = (world_w == 0) ? 1 : int'(world_w);
        wh = (world_h == 0) ? 1 : int'(world_h);
        stop = n_pushed + count;
        while (n_pushed < stop) begin
            if ($urandom_range(3) == 0) begin
                if ($urandom_range(7) == 0)
                    push_write($urandom_range((1 << ADDR_W) - 1, FRAME_SIZE),
                               $urandom_range(255));
                else
                    push_write($urandom_range(FRAME_SIZE - 1), $urandom_range(255));
            end else if ($urandom_range(4) < 3) begin
                push_query($urandom_range(ww * 256 + 255), $urandom_range(wh * 256 + 255));
            end else begin
                push_query($urandom_range((1 << QRY_W) - 1),
                           $urandom_range((1 << QRY_W) - 1));
            end
        end
    endtask

    task automatic drain();
        while (request_q.size() != 0 || start || height_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic int rnd_rot();
        return int'($urandom_range(32768)) - 16384;
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_write(0, 0);
        push_write(FRAME_SIZE - 1, 255);
        push_write(FRAME_SIZE, 17);
        push_write((1 << ADDR_W) - 1, 99);
        push_query(0, 0);
        push_query(640 * 256, 480 * 256);
        push_query((1 << QRY_W) - 1, (1 << QRY_W) - 1);
        push_query(0, (1 << QRY_W) - 1);
        push_query((1 << QRY_W) - 1, 0);
        push_query(320 * 256 + 128, 240 * 256 + 77);
        push_query(639 * 256 + 255, 479 * 256 + 1);
        push_write(FRAME_WIDTH, 255);
        push_write(1, 200);
        push_query(0, 128);
        push_query(128, 0);
        push_write(FRAME_SIZE - 2, 0);
        push_query(639 * 256, 479 * 256);
        drain();

        apply_setup(640, 480, 0, 640, 0, 480, 16384, 0);
        cfg_write(8'd200, 16'hffff);
        push_random(128);
        drain();

        apply_setup(0, 0, 640, 0, 480, 0, 16384, 0);
        push_random(128);
        drain();

        idle_pct = 62;
        apply_setup(65535, 65535, 100, 500, 50, 400, 0, 16384);
        push_random(128);
        drain();

        apply_setup(640, 480, 0, 640, 0, 480, -16384, 0);
        push_random(128);
        drain();

        idle_pct = 0;
        apply_setup($urandom_range(1, 65535), $urandom_range(1, 65535),
                    $urandom_range(640), $urandom_range(640),
                    $urandom_range(480), $urandom_range(480), rnd_rot(), rnd_rot());
        push_random(128);
        drain();

        apply_setup(1, 1, 640, 640, 480, 480, -16384, -16384);
        push_random(128);
        drain();

        apply_setup($urandom_range(1, 2000), $urandom_range(1, 2000),
                    $urandom_range(300), $urandom_range(340, 640),
                    $urandom_range(200), $urandom_range(280, 480), 11585, -11585);
        push_random(128);
        drain();

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
